>>> rtl/tbeq_pkg.sv
// ----------------------------------------------------------------------------
// tbeq_pkg: shared types and constants of the three band equalizer
// Register indexes, reset values, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package tbeq_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int CHAN_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int TRACK_W   = 32;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_POLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_POLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MID_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_GAIN = 3'd4;

    localparam logic [CFG_W-1:0] RST_LOW_POLE  = 16'd64010;
    localparam logic [CFG_W-1:0] RST_HIGH_POLE = 16'd41446;
    localparam logic [CFG_W-1:0] RST_GAIN      = 16'd4096;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOW_MUL,
        ST_LOW_ADD,
        ST_HIGH_MUL,
        ST_HIGH_ADD,
        ST_GAIN_LOW,
        ST_GAIN_MID,
        ST_GAIN_HIGH,
        ST_OUT
    } t_state;

endpackage

>>> rtl/tbeq_ram.sv
// ----------------------------------------------------------------------------
// tbeq_ram: generic single write port RAM
// One write and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module tbeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/three_band_equalizer.sv
// ----------------------------------------------------------------------------
// three_band_equalizer: per-channel three band equalizer
// Each item steps from the tracker updates through the gain products to ST_OUT;
//   unmapped channels go straight there. One item at a time: the single shared 17x33
//   multiplier (two tracker updates, three gain products) and the tracker RAM RMW.
// Reset (sync, active low): config to defaults, per-channel valid bits cleared
//   so all trackers read as zero; no clearing pass.
// ----------------------------------------------------------------------------
module three_band_equalizer #(
    parameter int CHANNELS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [tbeq_pkg::CHAN_W-1:0]           i_chan,
    input  logic signed [tbeq_pkg::SAMPLE_W-1:0]  i_sample_in,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [tbeq_pkg::CHAN_W-1:0]           o_chan_out,
    output logic signed [tbeq_pkg::SAMPLE_W-1:0]  o_sample_out,
    output logic                                  o_clipped,
    input  logic                                  i_cfg_we,
    input  logic [tbeq_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tbeq_pkg::CFG_W-1:0]            i_cfg_data
);

    import tbeq_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // configuration
    logic [CFG_W-1:0] r_low_pole, r_high_pole, r_low_gain, r_mid_gain, r_high_gain;

    // control
    t_state              r_state, n_state;
    logic [CHANNELS-1:0] r_valid;
    logic                r_vld_rd;
    logic                r_pass;
    logic [AW-1:0]       r_addr;

    // item payload and datapath
    logic [CHAN_W-1:0]          r_chan;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [31:0]         r_lo, r_hin, r_hi;
    logic signed [32:0]         r_hb;
    logic signed [49:0]         r_prod;
    logic signed [51:0]         r_acc;

    // output register
    logic                       r_o_valid;
    logic [CHAN_W-1:0]          r_o_chan;
    logic signed [SAMPLE_W-1:0] r_o_sample;
    logic                       r_o_clipped;

    logic              w_accept, w_in_range, w_out_free;
    logic [6:0]        w_chan_ext;
    logic [AW-1:0]     w_addr_in;
    logic [31:0]       w_low_rdata, w_high_rdata;
    logic signed [31:0] w_low_prev, w_high_prev;
    logic signed [30:0] w_xw;
    logic signed [32:0] w_d1, w_d2;
    logic [CFG_W-1:0]   w_mul_coef;
    logic signed [32:0] w_mul_op;
    logic signed [49:0] w_prod, w_rnd;
    logic signed [33:0] w_step;
    logic signed [34:0] w_lo_sum, w_hi_sum;
    logic signed [31:0] w_lo, w_hin, w_hi;
    logic signed [32:0] w_hb;
    logic signed [51:0] w_prod_ext, w_rnd_out;
    logic signed [32:0] w_y;
    logic signed [SAMPLE_W-1:0] w_y_sat;
    logic               w_clip;
    logic               w_low_we, w_high_we;

    assign o_stall    = !i_rst_n || (r_state != ST_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_chan_ext = {4'b0, i_chan};
    assign w_in_range = (w_chan_ext < 7'(CHANNELS));
    assign w_addr_in  = w_chan_ext[AW-1:0];
    assign w_out_free = !r_o_valid || !i_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_pole  <= RST_LOW_POLE;
            r_high_pole <= RST_HIGH_POLE;
            r_low_gain  <= RST_GAIN;
            r_mid_gain  <= RST_GAIN;
            r_high_gain <= RST_GAIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LOW_POLE:  r_low_pole  <= i_cfg_data;
                REG_HIGH_POLE: r_high_pole <= i_cfg_data;
                REG_LOW_GAIN:  r_low_gain  <= i_cfg_data;
                REG_MID_GAIN:  r_mid_gain  <= i_cfg_data;
                REG_HIGH_GAIN: r_high_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // tracker memories
    assign w_low_we  = (r_state == ST_LOW_ADD);
    assign w_high_we = (r_state == ST_HIGH_ADD);

    tbeq_ram #(
        .WIDTH (TRACK_W),
        .DEPTH (CHANNELS),
        .AW    (AW)
    ) u_low_ram (
        .i_clk   (i_clk),
        .i_we    (w_low_we),
        .i_waddr (r_addr),
        .i_wdata (w_lo),
        .i_re    (w_accept),
        .i_raddr (w_addr_in),
        .o_rdata (w_low_rdata)
    );

    tbeq_ram #(
        .WIDTH (TRACK_W),
        .DEPTH (CHANNELS),
        .AW    (AW)
    ) u_high_ram (
        .i_clk   (i_clk),
        .i_we    (w_high_we),
        .i_waddr (r_addr),
        .i_wdata (w_hi),
        .i_re    (w_accept),
        .i_raddr (w_addr_in),
        .o_rdata (w_high_rdata)
    );

    // never-written channels read as zero
    assign w_low_prev  = r_vld_rd ? $signed(w_low_rdata)  : 32'sd0;
    assign w_high_prev = r_vld_rd ? $signed(w_high_rdata) : 32'sd0;

    // tracker update: t' = v + floor((p*(t-v) + 2^15) / 2^16)
    assign w_xw = $signed({r_x, 7'b0});
    assign w_d1 = $signed({w_low_prev[31], w_low_prev}) - $signed({{2{w_xw[30]}}, w_xw});
    assign w_d2 = $signed({w_high_prev[31], w_high_prev}) - $signed({r_hin[31], r_hin});

    // shared multiplier operand select
    always_comb begin
        w_mul_coef = r_low_pole;
        w_mul_op   = w_d1;
        unique case (r_state)
            ST_HIGH_MUL: begin
                w_mul_coef = r_high_pole;
                w_mul_op   = w_d2;
            end
            ST_GAIN_LOW: begin
                w_mul_coef = r_low_gain;
                w_mul_op   = $signed({r_lo[31], r_lo});
            end
            ST_GAIN_MID: begin
                w_mul_coef = r_mid_gain;
                w_mul_op   = $signed({r_hi[31], r_hi});
            end
            ST_GAIN_HIGH: begin
                w_mul_coef = r_high_gain;
                w_mul_op   = r_hb;
            end
            default: ;
        endcase
    end

    assign w_prod     = $signed({1'b0, w_mul_coef}) * w_mul_op;
    assign w_prod_ext = $signed({{2{w_prod[49]}}, w_prod});

    assign w_rnd    = r_prod + 50'sd32768;
    assign w_step   = $signed(w_rnd[49:16]);
    assign w_lo_sum = $signed({{4{w_xw[30]}}, w_xw}) + $signed({w_step[33], w_step});
    assign w_lo     = w_lo_sum[31:0];
    assign w_hin    = $signed({w_xw[30], w_xw}) - w_lo;
    assign w_hi_sum = $signed({{3{r_hin[31]}}, r_hin}) + $signed({w_step[33], w_step});
    assign w_hi     = w_hi_sum[31:0];
    assign w_hb     = $signed({r_hin[31], r_hin}) - $signed({w_hi[31], w_hi});

    // round half up to Q1.23 and saturate
    assign w_rnd_out = r_acc + 52'sd262144;
    assign w_y       = $signed(w_rnd_out[51:19]);

    always_comb begin
        w_y_sat = w_y[SAMPLE_W-1:0];
        w_clip  = 1'b0;
        if (w_y > $signed({{9{1'b0}}, SAMPLE_MAX})) begin
            w_y_sat = SAMPLE_MAX;
            w_clip  = 1'b1;
        end else if (w_y < $signed({{9{1'b1}}, SAMPLE_MIN})) begin
            w_y_sat = SAMPLE_MIN;
            w_clip  = 1'b1;
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (w_accept) n_state = w_in_range ? ST_LOW_MUL : ST_OUT;
            ST_LOW_MUL:   n_state = ST_LOW_ADD;
            ST_LOW_ADD:   n_state = ST_HIGH_MUL;
            ST_HIGH_MUL:  n_state = ST_HIGH_ADD;
            ST_HIGH_ADD:  n_state = ST_GAIN_LOW;
            ST_GAIN_LOW:  n_state = ST_GAIN_MID;
            ST_GAIN_MID:  n_state = ST_GAIN_HIGH;
            ST_GAIN_HIGH: n_state = ST_OUT;
            ST_OUT:       if (w_out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_HIGH_ADD) begin
                r_valid[r_addr] <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_chan   <= i_chan;
            r_x      <= i_sample_in;
            r_addr   <= w_addr_in;
            r_pass   <= !w_in_range;
            r_vld_rd <= w_in_range && r_valid[w_addr_in];
        end
        unique case (r_state)
            ST_LOW_MUL, ST_HIGH_MUL: r_prod <= w_prod;
            ST_LOW_ADD: begin
                r_lo  <= w_lo;
                r_hin <= w_hin;
            end
            ST_HIGH_ADD: begin
                r_hi <= w_hi;
                r_hb <= w_hb;
            end
            ST_GAIN_LOW:               r_acc <= w_prod_ext;
            ST_GAIN_MID, ST_GAIN_HIGH: r_acc <= r_acc + w_prod_ext;
            default: ;
        endcase
    end

    // output register: holds a finished item while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == ST_OUT && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && w_out_free) begin
            r_o_chan <= r_chan;
            if (r_pass) begin
                r_o_sample  <= r_x;
                r_o_clipped <= 1'b0;
            end else begin
                r_o_sample  <= w_y_sat;
                r_o_clipped <= w_clip;
            end
        end
    end

    assign o_valid      = r_o_valid;
    assign o_chan_out   = r_o_chan;
    assign o_sample_out = r_o_sample;
    assign o_clipped    = r_o_clipped;

endmodule

>>> rtl/tbeq_checker.sv
// ----------------------------------------------------------------------------
// tbeq_checker: port level assertions for the three band equalizer
// Tracks items in flight and checks output hold, saturation, one-item intake and occupancy.
// ----------------------------------------------------------------------------
module tbeq_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 o_stall,
    input logic                                 o_valid,
    input logic                                 i_stall,
    input logic [tbeq_pkg::CHAN_W-1:0]          o_chan_out,
    input logic signed [tbeq_pkg::SAMPLE_W-1:0] o_sample_out,
    input logic                                 o_clipped
);

    import tbeq_pkg::*;

    logic [1:0] r_cnt;
    logic       w_in_acc, w_out_acc;

    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = o_valid && !i_stall;

    // items accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (w_in_acc && !w_out_acc) begin
            r_cnt <= r_cnt + 2'd1;
        end else if (w_out_acc && !w_in_acc) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sample_out)
            && $stable(o_chan_out) && $stable(o_clipped))
        else $error("output item changed while stalled");

    a_clip_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clipped |-> (o_sample_out == SAMPLE_MAX) || (o_sample_out == SAMPLE_MIN))
        else $error("clipped set on unsaturated sample");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_stall)
        else $error("second item taken while one is in work");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_cnt != 2'd0)
        else $error("output item without an accepted input item");

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("more than two items held");

endmodule

bind three_band_equalizer tbeq_checker u_tbeq_checker (.*);

>>> sim/three_band_equalizer_tb.sv
// ----------------------------------------------------------------------------
// three_band_equalizer_tb: self-checking bench for the three band equalizer
// A queue-fed driver sends channel-tagged samples. Each accepted item runs
// through a cycle-free model of the two one-pole trackers and the gain sum,
// and the monitor compares each result with the oldest prediction. Register
// settings change between phases while the block is idle. Both sides idle at
// random, and the receiver also holds off for long stretches.
// ----------------------------------------------------------------------------
module three_band_equalizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tbeq_pkg::*;

    localparam int N_CHAN = 8;

    typedef struct packed {
        logic [CHAN_W-1:0]          chan;
        logic signed [SAMPLE_W-1:0] sample;
    } eq_sample_t;

    typedef struct packed {
        logic [CHAN_W-1:0]          chan;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clipped;
    } eq_result_t;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_valid     = 1'b0;
    logic                       o_stall;
    logic [CHAN_W-1:0]          i_chan      = '0;
    logic signed [SAMPLE_W-1:0] i_sample_in = '0;
    logic                       o_valid;
    logic                       i_stall     = 1'b0;
    logic [CHAN_W-1:0]          o_chan_out;
    logic signed [SAMPLE_W-1:0] o_sample_out;
    logic                       o_clipped;
    logic                       i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_W-1:0]           i_cfg_data  = '0;

    // model copy of the registers and per-channel trackers
    logic [CFG_W-1:0]          low_pole_q  = RST_LOW_POLE;
    logic [CFG_W-1:0]          high_pole_q = RST_HIGH_POLE;
    logic [CFG_W-1:0]          low_gain_q  = RST_GAIN;
    logic [CFG_W-1:0]          mid_gain_q  = RST_GAIN;
    logic [CFG_W-1:0]          high_gain_q = RST_GAIN;
    logic signed [TRACK_W-1:0] low_trk  [N_CHAN] = '{default: '0};
    logic signed [TRACK_W-1:0] high_trk [N_CHAN] = '{default: '0};

    eq_sample_t samples_q[$];
    eq_result_t eq_expect_q[$];
    eq_sample_t next_item;
    eq_result_t want;

    bit no_idle      = 1'b0;
    int hold_left    = 0;
    int results_seen = 0;
    int error_cnt    = 0;
    int walk [N_CHAN] = '{default: 0};

    three_band_equalizer #(.CHANNELS(N_CHAN)) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_chan       (i_chan),
        .i_sample_in  (i_sample_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_chan_out   (o_chan_out),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("three_band_equalizer_tb failed");
        $finish;
    end

    task automatic report_err(input string msg);
        $display("%0t ERROR: %s", $realtime, msg);
        error_cnt++;
    endtask

    // t' = floor(((65536-p)*v + p*t + 2^15) / 2^16), all in Q2.30
    function automatic longint one_pole(input longint v, input longint prev,
                                        input logic [CFG_W-1:0] pole);
        longint p;
        p = longint'(pole);
        return ((65536 - p) * v + p * prev + 32768) >>> 16;
    endfunction

    task automatic predict_eq(input logic [CHAN_W-1:0] ch,
                              input logic signed [SAMPLE_W-1:0] x);
        longint xw, lo, hin, hi, hb, acc, y;
        eq_result_t r;
        xw  = longint'(x) * 128;
        lo  = one_pole(xw, longint'(low_trk[ch]), low_pole_q);
        hin = xw - lo;
        hi  = one_pole(hin, longint'(high_trk[ch]), high_pole_q);
        low_trk[ch]  = lo[TRACK_W-1:0];
        high_trk[ch] = hi[TRACK_W-1:0];
        hb  = hin - hi;
        acc = lo * longint'(low_gain_q) + hi * longint'(mid_gain_q)
            + hb * longint'(high_gain_q);
        // sum is in 2^-42 units; round half up to Q1.23
        y = (acc + 262144) >>> 19;
        r.chan    = ch;
        r.clipped = 1'b0;
        if (y > longint'(SAMPLE_MAX)) begin
            y = longint'(SAMPLE_MAX);
            r.clipped = 1'b1;
        end else if (y < longint'(SAMPLE_MIN)) begin
            y = longint'(SAMPLE_MIN);
            r.clipped = 1'b1;
        end
        r.sample = y[SAMPLE_W-1:0];
        eq_expect_q.push_back(r);
    endtask

    // driver: hold the item while stalled, else offer the next one or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_eq(i_chan, i_sample_in);
            end
            if (!i_valid || !o_stall) begin
                if (samples_q.size() != 0 && (no_idle || $urandom_range(99) >= 15)) begin
                    next_item = samples_q.pop_front();
                    i_valid     <= 1'b1;
                    i_chan      <= next_item.chan;
                    i_sample_in <= next_item.sample;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (eq_expect_q.size() == 0) begin
                    report_err($sformatf("unexpected item chan=%0d sample=%0d",
                                         o_chan_out, o_sample_out));
                end else begin
                    want = eq_expect_q.pop_front();
                    if (o_chan_out !== want.chan)
                        report_err($sformatf("chan_out %0d, expected %0d",
                                             o_chan_out, want.chan));
                    if (o_sample_out !== want.sample)
                        report_err($sformatf("chan %0d sample_out %0d, expected %0d",
                                             want.chan, o_sample_out, want.sample));
                    if (o_clipped !== want.clipped)
                        report_err($sformatf("chan %0d clipped %b, expected %b",
                                             want.chan, o_clipped, want.clipped));
                end
                results_seen++;
                // long back-pressure so the block fills and stalls its input
                if (results_seen == 100 || results_seen == 330)
                    hold_left = 120;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !no_idle && ($urandom_range(99) < 15);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            REG_LOW_POLE:  low_pole_q  = data;
            REG_HIGH_POLE: high_pole_q = data;
            REG_LOW_GAIN:  low_gain_q  = data;
            REG_MID_GAIN:  mid_gain_q  = data;
            REG_HIGH_GAIN: high_gain_q = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_eq(input logic [CFG_W-1:0] lp, input logic [CFG_W-1:0] hp,
                          input logic [CFG_W-1:0] gl, input logic [CFG_W-1:0] gm,
                          input logic [CFG_W-1:0] gh);
        write_reg(REG_LOW_POLE, lp);
        write_reg(REG_HIGH_POLE, hp);
        write_reg(REG_LOW_GAIN, gl);
        write_reg(REG_MID_GAIN, gm);
        write_reg(REG_HIGH_GAIN, gh);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (samples_q.size() != 0 || i_valid || eq_expect_q.size() != 0);
    endtask

    task automatic push_item(input int ch, input logic signed [SAMPLE_W-1:0] s);
        eq_sample_t it;
        it.chan   = ch[CHAN_W-1:0];
        it.sample = s;
        samples_q.push_back(it);
    endtask

    // mostly slow per-channel random walks, some noise, extremes and tiny values
    task automatic push_random(input int count);
        int ch, kind, w;
        ch = 0;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(1) == 0)
                ch = $urandom_range(N_CHAN - 1);
            kind = $urandom_range(99);
            if (kind < 70) begin
                w = walk[ch] + int'($urandom_range(524288)) - 262144;
                if (w > 8388607) w = 8388607;
                if (w < -8388608) w = -8388608;
                walk[ch] = w;
                push_item(ch, w[SAMPLE_W-1:0]);
            end else if (kind < 85) begin
                push_item(ch, SAMPLE_W'($urandom()));
            end else if (kind < 95) begin
                push_item(ch, $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN);
            end else begin
                w = int'($urandom_range(32)) - 16;
                push_item(ch, w[SAMPLE_W-1:0]);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: extremes and bit patterns on every channel
        push_item(0, SAMPLE_MAX);
        push_item(0, SAMPLE_MAX);
        push_item(1, SAMPLE_MIN);
        push_item(1, SAMPLE_MIN);
        push_item(2, 24'sd0);
        push_item(3, 24'sd1);
        push_item(4, -24'sd1);
        push_item(5, 24'sh555555);
        push_item(6, 24'shAAAAAA);
        push_item(7, SAMPLE_MAX);
        push_item(7, SAMPLE_MIN);
        push_item(0, SAMPLE_MIN);
        wait_drained();

        // maximum gains: saturation at both ends
        set_eq(RST_LOW_POLE, RST_HIGH_POLE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_item(3, SAMPLE_MAX);
        push_item(3, SAMPLE_MIN);
        push_item(5, SAMPLE_MAX);
        push_item(2, 24'sd3);
        wait_drained();

        // zero poles: trackers follow their input directly
        set_eq(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        push_item(6, SAMPLE_MAX);
        wait_drained();
        write_reg(REG_LOW_GAIN, 16'd8192);
        @(negedge i_clk);
        push_item(1, SAMPLE_MAX);
        push_item(1, 24'sh400000);
        push_item(1, 24'sh3FFFFF);
        push_item(4, SAMPLE_MIN);
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_eq(RST_LOW_POLE, RST_HIGH_POLE, RST_GAIN, RST_GAIN, RST_GAIN);
                1: set_eq(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
                2: set_eq(16'd0, 16'd0, CFG_W'($urandom()), CFG_W'($urandom()),
                          CFG_W'($urandom()));
                4: set_eq(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
                default: set_eq(CFG_W'($urandom()), CFG_W'($urandom()),
                                CFG_W'($urandom_range(16384)),
                                CFG_W'($urandom_range(16384)),
                                CFG_W'($urandom_range(16384)));
            endcase
            no_idle = (phase == 2);
            push_random(75);
            wait_drained();
        end
        no_idle = 1'b0;

        repeat (16) @(posedge i_clk);
        if (error_cnt == 0) begin
            $display("three_band_equalizer_tb passed");
        end else begin
            $display("three_band_equalizer_tb failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/tbeq_pkg.sv
rtl/tbeq_ram.sv
rtl/three_band_equalizer.sv
rtl/tbeq_checker.sv
sim/three_band_equalizer_tb.sv
